// File: rtl/jkie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkie_pkg
// Shared types and constants for the JSON key integer extractor.
// ----------------------------------------------------------------------------
package jkie_pkg;

  localparam int KEY_W       = 64;
  localparam int KEY_LEN_W   = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int NUMBER_W    = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_VALUE = 2'd3;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } text_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [NUMBER_W-1:0] number;
  } result_t;

  // one slot of the byte window
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } slot_t;

  typedef struct packed {
    logic                found;
    logic                value_ok;
    logic [NUMBER_W-1:0] number;
  } parse_res_t;

endpackage

// File: rtl/jkie_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkie_cell
// One window cell: holds a text byte, passes it on, compares against key.
// ----------------------------------------------------------------------------
module jkie_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  logic           clear,
  input  jkie_pkg::slot_t slot_in,
  input  logic [7:0]     want,
  input  logic           active,
  output jkie_pkg::slot_t slot,
  output logic           hit
);

  // compare the value this cell takes on at this shift
  assign hit = !active || (slot_in.valid && (slot_in.data == want));

  always_ff @(posedge clk) begin
    if (rst || (shift && clear)) begin
      slot.valid <= 1'b0;
    end else if (shift) begin
      slot.valid <= slot_in.valid;
    end
    if (shift) begin
      slot.data <= slot_in.data;
    end
  end

endmodule

// File: rtl/jkie_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkie_parse
// Key-found sequencer and decimal value accumulator with saturation.
// ----------------------------------------------------------------------------
module jkie_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  clear,
  input  logic [7:0]            text_byte,
  input  logic                  key_hit,
  output jkie_pkg::parse_res_t  res
);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_SKIP1  = 3'd1;
  localparam logic [2:0] PH_SKIP2  = 3'd2;
  localparam logic [2:0] PH_FIRST  = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_BAD    = 3'd6;

  localparam logic [35:0] MAG_LIMIT = 36'h080000000;

  logic [2:0]  phase, phase_next;
  logic        negative, negative_next;
  logic [31:0] magnitude, magnitude_next;
  logic        is_digit;
  logic [35:0] mag_wide, mag_sum;
  logic [31:0] mag_added;

  assign is_digit = (text_byte >= jkie_pkg::CH_ZERO) && (text_byte <= jkie_pkg::CH_NINE);

  // magnitude * 10 + digit, clamped at 2^31
  assign mag_wide  = {4'b0, magnitude};
  assign mag_sum   = (mag_wide << 3) + (mag_wide << 1) +
                     {28'b0, text_byte - jkie_pkg::CH_ZERO};
  assign mag_added = (mag_sum > MAG_LIMIT) ? MAG_LIMIT[31:0] : mag_sum[31:0];

  always_comb begin
    phase_next     = phase;
    negative_next  = negative;
    magnitude_next = magnitude;
    unique case (phase)
      PH_SEARCH: begin
        if (key_hit) phase_next = PH_SKIP1;
      end
      PH_SKIP1: phase_next = PH_SKIP2;
      PH_SKIP2: phase_next = PH_FIRST;
      PH_FIRST: begin
        if (text_byte == jkie_pkg::CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_DIGITS;
        end else if (is_digit) begin
          magnitude_next = mag_added;
          phase_next     = PH_DIGITS;
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (is_digit) magnitude_next = mag_added;
        else          phase_next     = PH_DONE;
      end
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    res.found    = (phase_next != PH_SEARCH);
    res.value_ok = (phase_next == PH_DIGITS) || (phase_next == PH_DONE);
    if (negative_next) begin
      res.number = 32'd0 - magnitude_next;
    end else if (magnitude_next[31]) begin
      res.number = 32'h7FFF_FFFF;
    end else begin
      res.number = magnitude_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      phase     <= PH_SEARCH;
      negative  <= 1'b0;
      magnitude <= 32'd0;
    end else if (step) begin
      phase     <= phase_next;
      negative  <= negative_next;
      magnitude <= magnitude_next;
    end
  end

endmodule

// File: rtl/json_key_integer_extract.sv
`timescale 1ns / 1ps
// The result word appears in the cycle after the final text byte is taken.
// Throughput: one text byte per cycle unless a result word waits unread; the
//   key compare spans the window cells; the digit accumulate is a 36-bit add.
// The output register frees in the same cycle it is read, so no bubbles.
// Reset: synchronous; clears window, flags, parser and sets key_length to 1.
// ----------------------------------------------------------------------------
// json_key_integer_extract
// Streams a JSON text, finds a configured key and returns its integer value.
// ----------------------------------------------------------------------------
module json_key_integer_extract #(
  parameter int MAX_KEY_BYTES = 8,
  parameter int TEXT_BYTES    = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             text_valid,
  output logic                             text_ready,
  input  jkie_pkg::text_t                  text_word,
  output logic                             result_valid,
  input  logic                             result_ready,
  output jkie_pkg::result_t                result_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [jkie_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jkie_pkg::KEY_W-1:0]       cfg_data
);

  localparam int CNT_W = $clog2(TEXT_BYTES + 1);

  logic [jkie_pkg::KEY_W-1:0]     key_bytes;
  logic [jkie_pkg::KEY_LEN_W-1:0] key_length;
  logic [jkie_pkg::KEY_LEN_W-1:0] key_len_eff;

  logic             started, opens_with_brace, quote_seen, colon_seen;
  logic             opens_next, quote_next, colon_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;

  logic             step, last, malformed;
  logic [7:0]       text_byte;

  jkie_pkg::slot_t           slot_chain [MAX_KEY_BYTES+1];
  logic [MAX_KEY_BYTES-1:0]  hits;
  jkie_pkg::parse_res_t      pres;
  jkie_pkg::result_t         result_next;

  assign text_byte  = text_word.text_byte;
  assign last       = text_word.final_byte;
  assign text_ready = !result_valid || result_ready;
  assign step       = text_valid && text_ready;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes  <= '0;
      key_length <= jkie_pkg::KEY_LEN_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == jkie_pkg::REG_KEY_BYTES) begin
        key_bytes <= cfg_data;
      end else if (cfg_index == jkie_pkg::REG_KEY_LENGTH) begin
        key_length <= cfg_data[jkie_pkg::KEY_LEN_W-1:0];
      end
    end
  end

  always_comb begin
    if (key_length == '0) begin
      key_len_eff = jkie_pkg::KEY_LEN_W'(1);
    end else if (key_length > jkie_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
      key_len_eff = jkie_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
    end else begin
      key_len_eff = key_length;
    end
  end

  // newest byte enters cell 0
  assign slot_chain[0].valid = 1'b1;
  assign slot_chain[0].data  = text_byte;

  for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_cell
    logic [jkie_pkg::KEY_LEN_W-1:0] sel;
    logic [7:0]                     want;
    logic                           active;

    assign active = jkie_pkg::KEY_LEN_W'(i) < key_len_eff;
    assign sel    = key_len_eff - jkie_pkg::KEY_LEN_W'(1) - jkie_pkg::KEY_LEN_W'(i);
    assign want   = key_bytes[{sel[2:0], 3'b000} +: 8];

    jkie_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (step),
      .clear   (last),
      .slot_in (slot_chain[i]),
      .want    (want),
      .active  (active),
      .slot    (slot_chain[i+1]),
      .hit     (hits[i])
    );
  end

  jkie_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .clear     (last),
    .text_byte (text_byte),
    .key_hit   (&hits),
    .res       (pres)
  );

  assign opens_next      = started ? opens_with_brace : (text_byte == jkie_pkg::CH_LBRACE);
  assign quote_next      = quote_seen || (text_byte == jkie_pkg::CH_QUOTE);
  assign colon_next      = colon_seen || (text_byte == jkie_pkg::CH_COLON);
  assign byte_count_next = (byte_count == CNT_W'(TEXT_BYTES)) ? byte_count
                                                              : byte_count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      started          <= 1'b0;
      opens_with_brace <= 1'b0;
      quote_seen       <= 1'b0;
      colon_seen       <= 1'b0;
      byte_count       <= '0;
    end else if (step) begin
      started          <= 1'b1;
      opens_with_brace <= opens_next;
      quote_seen       <= quote_next;
      colon_seen       <= colon_next;
      byte_count       <= byte_count_next;
    end
  end

  assign malformed = !opens_next || (text_byte != jkie_pkg::CH_RBRACE) || !quote_next ||
                     !colon_next || (byte_count_next >= CNT_W'(TEXT_BYTES));

  always_comb begin
    result_next.number = '0;
    priority if (malformed) begin
      result_next.status = jkie_pkg::ST_MALFORMED;
    end else if (!pres.found) begin
      result_next.status = jkie_pkg::ST_NOT_FOUND;
    end else if (!pres.value_ok) begin
      result_next.status = jkie_pkg::ST_BAD_VALUE;
    end else begin
      result_next.status = jkie_pkg::ST_OK;
      result_next.number = pres.number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last) begin
      result_word <= result_next;
    end
  end

endmodule

// File: verif/json_key_integer_extract_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_key_integer_extract_test
// Streams JSON texts byte by byte through the key integer extractor and checks
// every result word against a cycle-free model of the key search and number
// parse. Short directed texts first, then random texts under several key
// settings and several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module json_key_integer_extract_test;

  localparam int KEY_SLOTS  = 8;
  localparam int TEXT_LIMIT = 1024;
  localparam int IDLE_LIMIT = 3000;

  // indexes the block has no register for
  localparam logic [jkie_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [jkie_pkg::CFG_INDEX_W-1:0] REG_UNUSED_HI = 2'd3;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;

  // Tracks one text at a time and queues the status/number it must produce.
  class key_value_board;
    typedef enum logic [2:0] {SEEK, SKIP_A, SKIP_B, FIRST, DIGITS, DONE, BAD} phase_e;

    logic [63:0]       key_bytes;
    logic [3:0]        key_length;
    logic [7:0]        window [KEY_SLOTS];
    bit                started, opens_brace, has_quote, has_colon, negative;
    phase_e            phase;
    logic [31:0]       magnitude;
    int                text_len;
    jkie_pkg::result_t expected_q [$];

    function new();
      key_bytes  = '0;
      key_length = 4'd1;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[k]) window[k] = '0;
      started     = 0;
      opens_brace = 0;
      has_quote   = 0;
      has_colon   = 0;
      negative    = 0;
      phase       = SEEK;
      magnitude   = '0;
      text_len    = 0;
    endfunction

    function void write_reg(logic [jkie_pkg::CFG_INDEX_W-1:0] index,
                            logic [jkie_pkg::KEY_W-1:0] data);
      if (index == jkie_pkg::REG_KEY_BYTES) key_bytes = data;
      else if (index == jkie_pkg::REG_KEY_LENGTH) key_length = data[jkie_pkg::KEY_LEN_W-1:0];
    endfunction

    function bit digit(logic [7:0] b);
      return b >= jkie_pkg::CH_ZERO && b <= jkie_pkg::CH_NINE;
    endfunction

    // newest byte sits in window[0]; key character 0 lines up with the oldest
    function bit key_hit();
      int span;
      span = (key_length == 0) ? 1 : ((key_length > KEY_SLOTS) ? KEY_SLOTS : key_length);
      if (text_len < span) return 0;
      for (int k = 0; k < span; k++)
        if (window[span-1-k] != key_bytes[8*k +: 8]) return 0;
      return 1;
    endfunction

    function void add_digit(logic [7:0] b);
      logic [63:0] m;
      m = {32'd0, magnitude} * 64'd10 + {56'd0, b} - 64'd48;
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      magnitude = m[31:0];
    endfunction

    function void take_byte(jkie_pkg::text_t w);
      logic [7:0]        b;
      jkie_pkg::result_t res;
      b = w.text_byte;
      if (!started) begin
        started     = 1;
        opens_brace = (b == jkie_pkg::CH_LBRACE);
      end
      if (b == jkie_pkg::CH_QUOTE) has_quote = 1;
      if (b == jkie_pkg::CH_COLON) has_colon = 1;
      if (text_len < TEXT_LIMIT) text_len++;
      for (int k = KEY_SLOTS - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;

      case (phase)
        SEEK:   if (key_hit()) phase = SKIP_A;
        SKIP_A: phase = SKIP_B;
        SKIP_B: phase = FIRST;
        FIRST: begin
          if (b == jkie_pkg::CH_MINUS) begin
            negative = 1;
            phase    = DIGITS;
          end else if (digit(b)) begin
            add_digit(b);
            phase = DIGITS;
          end else begin
            phase = BAD;
          end
        end
        DIGITS: begin
          if (digit(b)) add_digit(b);
          else phase = DONE;
        end
        default: ;
      endcase

      if (!w.final_byte) return;

      res.number = '0;
      if (!opens_brace || b != jkie_pkg::CH_RBRACE || !has_quote || !has_colon ||
          text_len > TEXT_LIMIT - 1) begin
        res.status = jkie_pkg::ST_MALFORMED;
      end else if (phase == SEEK) begin
        res.status = jkie_pkg::ST_NOT_FOUND;
      end else if (phase != DIGITS && phase != DONE) begin
        res.status = jkie_pkg::ST_BAD_VALUE;
      end else begin
        res.status = jkie_pkg::ST_OK;
        if (negative) res.number = 32'd0 - magnitude;
        else res.number = (magnitude > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : magnitude;
      end
      expected_q.push_back(res);
      clear_text();
    endfunction

    function string check_result(jkie_pkg::result_t got);
      jkie_pkg::result_t want;
      if (expected_q.size() == 0)
        return $sformatf("result word with no text pending: status %0d number %0d",
                         got.status, got.number);
      want = expected_q.pop_front();
      if (got.status != want.status || got.number != want.number)
        return $sformatf("status %0d (want %0d), number %0d (want %0d)",
                         got.status, want.status, got.number, want.number);
      return "";
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             text_valid;
  logic                             text_ready;
  jkie_pkg::text_t                  text_word;
  logic                             result_valid;
  logic                             result_ready = 1'b0;
  jkie_pkg::result_t                result_word;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [jkie_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [jkie_pkg::KEY_W-1:0]       cfg_data;

  key_value_board board;

  int                mismatch_count = 0;
  int                idle_cycles = 0;
  int                gap_pct = 0;
  int                stall_pct = 0;
  int                sent_bytes = 0;
  logic [7:0]        text_buf [$];
  logic [63:0]       key_reg;
  int                key_span;
  jkie_pkg::result_t arrived [$];

  json_key_integer_extract #(
    .MAX_KEY_BYTES(KEY_SLOTS),
    .TEXT_BYTES   (TEXT_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .text_word   (text_word),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_word (result_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report(string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) arrived.push_back(result_word);
  end

  // compare on the falling edge so input-side bookkeeping of the same edge is done
  always @(negedge clk) begin : compare_results
    string msg;
    while (arrived.size() != 0) begin
      msg = board.check_result(arrived.pop_front());
      if (msg != "") report(msg);
    end
  end

  always @(posedge clk) begin
    if (rst || (text_valid && text_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    jkie_pkg::text_t w;
    w.text_byte  = b;
    w.final_byte = fin;
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text_word  <= w;
    do @(posedge clk); while (!text_ready);
    board.take_byte(w);
    sent_bytes++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // stop sending and let every pending result drain before touching registers
  task automatic settle();
    @(negedge clk);
    text_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [jkie_pkg::CFG_INDEX_W-1:0] index,
                           input logic [jkie_pkg::KEY_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push(input logic [7:0] b);
    text_buf.push_back(b);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push(s[i]);
  endtask

  task automatic push_digits(input int n);
    repeat (n) push(8'($urandom_range(jkie_pkg::CH_ZERO, jkie_pkg::CH_NINE)));
  endtask

  task automatic push_letters(input int n);
    repeat (n) push(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
  endtask

  task automatic push_key();
    for (int k = 0; k < key_span; k++) push(key_reg[8*k +: 8]);
  endtask

  task automatic say(input string s);
    text_buf.delete();
    push_str(s);
    send_text();
  endtask

  task automatic new_key();
    logic [63:0] kb;
    logic [63:0] len_word;
    logic [3:0]  len;
    len      = 4'($urandom_range(0, 15));
    key_span = (len == 0) ? 1 : ((len > KEY_SLOTS) ? KEY_SLOTS : len);
    kb       = {$urandom, $urandom};
    for (int k = 0; k < key_span; k++)
      kb[8*k +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                : 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
    key_reg  = kb;
    len_word = {$urandom, $urandom};
    len_word[jkie_pkg::KEY_LEN_W-1:0] = len;
    cfg_write(jkie_pkg::REG_KEY_BYTES, kb);
    cfg_write(jkie_pkg::REG_KEY_LENGTH, len_word);
    if ($urandom_range(0, 7) == 0) cfg_write(REG_UNUSED_HI, {$urandom, $urandom});
  endtask

  task automatic push_value();
    string extremes [6];
    extremes = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                 "42949672960", "0"};
    case ($urandom_range(0, 9))
      0: ;                                                // value missing
      1: push(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));    // not a number
      2: push(jkie_pkg::CH_MINUS);                        // lone minus
      3: begin
        push(jkie_pkg::CH_MINUS);
        push_digits($urandom_range(1, 12));
      end
      4: push_digits($urandom_range(10, 12));
      5: push_str(extremes[$urandom_range(0, 5)]);
      default: begin
        if ($urandom_range(0, 2) == 0) push(jkie_pkg::CH_MINUS);
        push_digits($urandom_range(1, 9));
      end
    endcase
  endtask

  task automatic push_member();
    push(jkie_pkg::CH_QUOTE);
    push_letters($urandom_range(1, 4));
    push(jkie_pkg::CH_QUOTE);
    push(jkie_pkg::CH_COLON);
    push_digits($urandom_range(1, 3));
  endtask

  // mostly well-formed objects holding the key; the rest broken or noise
  task automatic build_text();
    int kind;
    text_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 16)) push(8'($urandom_range(1, 255)));
      return;
    end
    push((kind < 12) ? 8'($urandom_range(1, 255)) : jkie_pkg::CH_LBRACE);
    if ($urandom_range(0, 3) == 0) begin
      push_member();
      push(CH_COMMA);
    end
    push(jkie_pkg::CH_QUOTE);
    if (kind < 18) push_letters($urandom_range(1, 8));
    else push_key();
    if (kind < 22) begin
      push(8'($urandom_range(1, 255)));
      push(8'($urandom_range(1, 255)));
    end else begin
      push(jkie_pkg::CH_QUOTE);
      push(jkie_pkg::CH_COLON);
    end
    push_value();
    if ($urandom_range(0, 3) == 0) begin
      push(CH_COMMA);
      push_member();
    end
    if (kind < 26) begin
      if ($urandom_range(0, 1) == 0) push(8'($urandom_range(1, 255)));
    end else begin
      push(jkie_pkg::CH_RBRACE);
    end
  endtask

  task automatic build_long(input int total);
    text_buf.delete();
    push(jkie_pkg::CH_LBRACE);
    push(jkie_pkg::CH_QUOTE);
    push_key();
    push(jkie_pkg::CH_QUOTE);
    push(jkie_pkg::CH_COLON);
    push_digits(3);
    push(CH_COMMA);
    while (text_buf.size() < total - 1) push(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
    push(jkie_pkg::CH_RBRACE);
  endtask

  initial begin
    int gap_mix [4];
    int stall_mix [4];
    int budget;
    board     = new();
    gap_mix   = '{0, 75, 0, 14};
    stall_mix = '{0, 0, 75, 14};
    text_valid = 1'b0;
    text_word  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = jkie_pkg::REG_KEY_BYTES;
    cfg_data   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset key is a single zero character: a zero byte in the text matches it
    text_buf.delete();
    push_str("{\"");
    push(8'h00);
    push_str("\":5}");
    send_text();

    // all-ones key with length field 15, clamped to eight characters
    settle();
    cfg_write(jkie_pkg::REG_KEY_BYTES, '1);
    cfg_write(jkie_pkg::REG_KEY_LENGTH, '1);
    text_buf.delete();
    push_str("{\"");
    repeat (8) push(8'hFF);
    push_str("\":-12}");
    send_text();

    // length 0 acts as 1; a lone closing brace is malformed
    settle();
    cfg_write(jkie_pkg::REG_KEY_BYTES, '0);
    cfg_write(jkie_pkg::REG_KEY_LENGTH, '0);
    cfg_write(REG_UNUSED_LO, '1);
    say("}");

    settle();
    cfg_write(jkie_pkg::REG_KEY_BYTES, 64'h61);
    cfg_write(jkie_pkg::REG_KEY_LENGTH, 64'h1);
    say("{\"a\":2147483647}");
    say("{\"a\":-2147483648}");
    say("{\"a\":99999999999}");
    say("{\"a\":-99999999999}");
    say("{\"a\":-}");
    say("{\"a\":x}");
    say("{:\"a\"}");
    say("{\"b\":1}");
    say("{\"a\":1");
    say("{a1}");
    say("{\"a\":12,\"b\":3}");

    // key of two zeros and a brace must not match the zeroed window at the start
    settle();
    cfg_write(jkie_pkg::REG_KEY_BYTES, 64'h7B_0000);
    cfg_write(jkie_pkg::REG_KEY_LENGTH, 64'h3);
    say("{\"a\":1}");

    settle();
    cfg_write(jkie_pkg::REG_KEY_BYTES, 64'h6867_6665_6463_6261);
    cfg_write(jkie_pkg::REG_KEY_LENGTH, 64'h8);
    say("{\"abcdefgh\":4}");

    for (int p = 0; p < 4; p++) begin
      settle();
      gap_pct   = gap_mix[p];
      stall_pct = stall_mix[p];
      budget    = sent_bytes + 50;
      while (sent_bytes < budget) begin
        settle();
        new_key();
        repeat ($urandom_range(1, 3)) begin
          build_text();
          send_text();
        end
      end
      // text length limit: a text that reaches it is malformed
      if (p == 3) begin
        build_long(TEXT_LIMIT);
        send_text();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: json_key_integer_extract.f
rtl/jkie_pkg.sv
rtl/jkie_cell.sv
rtl/jkie_parse.sv
rtl/json_key_integer_extract.sv
verif/json_key_integer_extract_test.sv
